// ===== rtl/bsst_pkg.sv =====
// Package: beat types, queue entry type and constants for the seed similarity test.
package bsst_pkg;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] entry_value;
    logic signed [31:0] seed_value;
    logic               last_entry;
  } in_beat_t;

  typedef struct packed {
    logic        accepted;
    logic [12:0] good_count;
    logic [12:0] bad_count;
    logic [12:0] entry_total;
  } out_beat_t;

  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_GOOD = 2'd1,
    CLS_BAD  = 2'd2
  } entry_cls_e;

  typedef struct packed {
    entry_cls_e cls;
    logic       mode;
    logic       last;
  } q_entry_t;

  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 16;

  localparam logic [CfgIdxW-1:0] REG_MAX_REL_DIFF = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_DROPOUT_RATE = 1'd1;

  localparam logic [CfgW-1:0] MaxRelDiffRst  = 16'd256;
  localparam logic [CfgW-1:0] DropoutRateRst = 16'd0;

  localparam int unsigned QDepth = 4;

endpackage

// ===== rtl/bsst_front.sv =====
// Front end: input register, tolerance multiply and entry classification.
module bsst_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  bsst_pkg::in_beat_t     in_beat_i,
  input  logic [15:0]            max_rel_diff_i,
  output logic                   push_o,
  output bsst_pkg::q_entry_t     push_data_o,
  input  logic                   q_full_i
);
  import bsst_pkg::*;

  logic               vld_q, vld_d;
  logic               load;
  logic               zero_q;
  logic               mode_q;
  logic               last_q;
  logic [32:0]        absd_q;
  logic signed [48:0] prod_q;
  logic signed [32:0] diff;
  logic signed [48:0] lhs;

  assign in_stall_o = vld_q & q_full_i;
  assign load       = in_valid_i & ~in_stall_o;
  assign push_o     = vld_q & ~q_full_i;
  assign vld_d      = load | (vld_q & ~push_o);

  // 33-bit exact difference, magnitude fits 33 bits unsigned
  assign diff = {in_beat_i.entry_value[31], in_beat_i.entry_value}
              - {in_beat_i.seed_value[31], in_beat_i.seed_value};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      zero_q <= (in_beat_i.entry_value == 32'sd0);
      mode_q <= in_beat_i.mode;
      last_q <= in_beat_i.last_entry;
      absd_q <= diff[32] ? 33'(-diff) : 33'(diff);
      prod_q <= $signed({1'b0, max_rel_diff_i}) * in_beat_i.seed_value;
    end
  end

  // 256*|d| against tolerance*seed
  assign lhs = $signed({8'd0, absd_q, 8'd0});

  always_comb begin
    push_data_o.mode = mode_q;
    push_data_o.last = last_q;
    if (zero_q) begin
      push_data_o.cls = CLS_ZERO;
    end else if (lhs <= prod_q) begin
      push_data_o.cls = CLS_GOOD;
    end else begin
      push_data_o.cls = CLS_BAD;
    end
  end

endmodule

// ===== rtl/bsst_fifo.sv =====
// Short queue of classified entries between front and back end.
module bsst_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bsst_pkg::q_entry_t push_data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output bsst_pkg::q_entry_t pop_data_o
);
  import bsst_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);

  q_entry_t          mem_q [QDepth];
  logic [PtrW-1:0]   wptr_q, rptr_q;
  logic [PtrW:0]     cnt_q, cnt_d;

  assign full_o     = (cnt_q == (PtrW+1)'(QDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/bsst_back.sv =====
// Back end: saturating tallies, verdict and output register.
module bsst_back #(
  parameter int unsigned MAX_ENTRIES = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  bsst_pkg::q_entry_t  q_data_i,
  output logic                pop_o,
  input  logic [15:0]         dropout_rate_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output bsst_pkg::out_beat_t out_beat_o
);
  import bsst_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_ENTRIES);

  function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] c);
    sat_inc = (c < MaxCnt) ? c + 1'b1 : MaxCnt;
  endfunction

  logic [CntW-1:0] good_q, bad_q, zero_q, n_q;
  logic            viol_q;
  logic [CntW-1:0] good_d, bad_d, zero_d, n_d;
  logic            viol_d;

  // verdict stage
  logic            a_vld_q;
  logic            a_mode_q;
  logic            a_viol_q;
  logic [CntW-1:0] a_good_q, a_bad_q, a_zero_q, a_n_q;
  logic            a_adv;

  logic            out_vld_q;
  out_beat_t       out_q;
  logic            out_load;

  logic [CntW+15:0] nr;
  logic [16:0]      rinv;
  logic [CntW+16:0] nq;
  logic             acc;
  logic [31:0]      good_x, bad_x, n_x;

  assign out_load = ~out_vld_q | ~out_stall_i;
  assign a_adv    = a_vld_q & out_load;
  assign pop_o    = q_valid_i & (~q_data_i.last | ~a_vld_q | a_adv);

  always_comb begin
    n_d    = sat_inc(n_q);
    good_d = good_q;
    bad_d  = bad_q;
    zero_d = zero_q;
    viol_d = viol_q;
    unique case (q_data_i.cls)
      CLS_ZERO: begin
        zero_d = sat_inc(zero_q);
        bad_d  = sat_inc(bad_q);
      end
      CLS_GOOD: begin
        good_d = sat_inc(good_q);
      end
      default: begin
        bad_d  = sat_inc(bad_q);
        viol_d = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      good_q    <= '0;
      bad_q     <= '0;
      zero_q    <= '0;
      n_q       <= '0;
      viol_q    <= 1'b0;
      a_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (pop_o) begin
        if (q_data_i.last) begin
          good_q <= '0;
          bad_q  <= '0;
          zero_q <= '0;
          n_q    <= '0;
          viol_q <= 1'b0;
        end else begin
          good_q <= good_d;
          bad_q  <= bad_d;
          zero_q <= zero_d;
          n_q    <= n_d;
          viol_q <= viol_d;
        end
      end
      if (pop_o && q_data_i.last) begin
        a_vld_q <= 1'b1;
      end else if (a_adv) begin
        a_vld_q <= 1'b0;
      end
      if (out_load) begin
        out_vld_q <= a_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && q_data_i.last) begin
      a_mode_q <= q_data_i.mode;
      a_viol_q <= viol_d;
      a_good_q <= good_d;
      a_bad_q  <= bad_d;
      a_zero_q <= zero_d;
      a_n_q    <= n_d;
    end
    if (a_adv) begin
      out_q.accepted    <= acc;
      out_q.good_count  <= good_x[12:0];
      out_q.bad_count   <= bad_x[12:0];
      out_q.entry_total <= n_x[12:0];
    end
  end

  // n*r and n*(1-r) in Q.16
  assign nr   = a_n_q * dropout_rate_i;
  assign rinv = 17'h10000 - {1'b0, dropout_rate_i};
  assign nq   = a_n_q * rinv;

  always_comb begin
    if (a_mode_q) begin
      acc = ({a_zero_q, 16'd0} <= nr) & ~a_viol_q;
    end else begin
      acc = (a_bad_q <= nr[CntW+15:16]) & ({1'b0, a_good_q, 16'd0} >= nq);
    end
  end

  assign good_x = 32'(a_good_q);
  assign bad_x  = 32'(a_bad_q);
  assign n_x    = 32'(a_n_q);

  assign out_valid_o = out_vld_q;
  assign out_beat_o  = out_q;

endmodule

// ===== rtl/bicluster_seed_similarity_test.sv =====
// Top level: seed similarity test for one bicluster candidate vector.
// A last entry passes the input register, queue and verdict stage to the result register.
// Throughput: one entry beat per cycle unless stalled; front multiplies, back counts.
// Result beats come only for entries flagged last; others only update the tallies.
// Reset (rst_ni low, async): tallies and queue cleared, tolerance 1.0, dropout rate 0.
// A stalled output does not stall input until the 4-deep queue and stages fill.
module bicluster_seed_similarity_test #(
  parameter int unsigned MAX_ENTRIES = 4096
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // entry channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  bsst_pkg::in_beat_t                 in_beat_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output bsst_pkg::out_beat_t                out_beat_o,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [bsst_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [bsst_pkg::CfgW-1:0]          cfg_wdata_i
);
  import bsst_pkg::*;

  logic [CfgW-1:0] max_rel_diff_q;
  logic [CfgW-1:0] dropout_rate_q;

  logic     push;
  q_entry_t push_data;
  logic     q_full;
  logic     pop;
  logic     q_valid;
  q_entry_t q_data;

  // config registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_rel_diff_q <= MaxRelDiffRst;
      dropout_rate_q <= DropoutRateRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAX_REL_DIFF: max_rel_diff_q <= cfg_wdata_i;
        REG_DROPOUT_RATE: dropout_rate_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // front: register the beat with |v-s| and tolerance*seed, classify on the way out
  bsst_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_beat_i      (in_beat_i),
    .max_rel_diff_i (max_rel_diff_q),
    .push_o         (push),
    .push_data_o    (push_data),
    .q_full_i       (q_full)
  );

  // decoupling queue of classified entries
  bsst_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_data)
  );

  // back: tallies, verdict on the last entry, result register
  bsst_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_data_i       (q_data),
    .pop_o          (pop),
    .dropout_rate_i (dropout_rate_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_beat_o     (out_beat_o)
  );

endmodule

// ===== rtl/bsst_checker.sv =====
// Checker on the result port of the seed similarity test, with its bind.
module bsst_checker #(
  parameter int unsigned MAX_ENTRIES = 4096
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input bsst_pkg::out_beat_t out_beat_o
);
  import bsst_pkg::*;

  localparam logic [13:0] MaxCnt = 14'(MAX_ENTRIES);

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_beat_o))
    else $error("result beat changed under stall");

  // every vector has at least its last entry
  a_total_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_beat_o.entry_total != 13'd0)
    else $error("result with empty vector");

  // unsaturated: each entry is either good or bad
  a_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ({1'b0, out_beat_o.entry_total} < MaxCnt) |->
      ({1'b0, out_beat_o.good_count} + {1'b0, out_beat_o.bad_count}
       == {1'b0, out_beat_o.entry_total}))
    else $error("good plus bad differs from entry total");

  // neither tally can run past the entry total
  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_beat_o.good_count <= out_beat_o.entry_total &&
                    out_beat_o.bad_count <= out_beat_o.entry_total)
    else $error("tally exceeds entry total");

endmodule

bind bicluster_seed_similarity_test bsst_checker #(
  .MAX_ENTRIES (MAX_ENTRIES)
) u_bsst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_beat_o  (out_beat_o)
);

// ===== verif/tb.sv =====
// Testbench for the seed similarity test: queue-fed driver, clocked monitor, verdict predictor.
module tb;
  import bsst_pkg::*;

  localparam int unsigned MAX_ENTRIES = 4096;
  // Result beats trail their last entry through the front, queue and back; allow a margin.
  localparam int unsigned DRAIN = 12;
  localparam int unsigned LONG_HOLD = 300;
  localparam logic MODE_ROW = 1'b0;
  localparam logic MODE_COL = 1'b1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  in_beat_t in_beat = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_beat_t out_beat;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgW-1:0] cfg_wdata = '0;

  bicluster_seed_similarity_test #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_beat_o  (out_beat),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #2 clk_i = ~clk_i;

  // Entry beats waiting to be offered, and verdicts waiting to come out.
  in_beat_t  entry_q[$];
  out_beat_t verdict_q[$];

  // Our copy of the registers, written alongside each port write.
  logic [15:0] tol_q88 = MaxRelDiffRst;
  logic [15:0] drop_q016 = DropoutRateRst;

  // Predictor tallies for the candidate in flight.
  logic [12:0] n_good = '0;
  logic [12:0] n_bad = '0;
  logic [12:0] n_zero = '0;
  logic [12:0] n_seen = '0;
  logic        nz_failed = 1'b0;

  // Idling knobs, set per phase while the block is idle.
  int unsigned src_gap_pct = 0;
  int unsigned snk_gap_pct = 0;
  logic        calm = 1'b0;

  int unsigned beats_in = 0;
  int unsigned verdicts_seen = 0;
  int unsigned mismatches = 0;
  int unsigned settings_run = 0;

  function automatic logic [12:0] sat_inc(input logic [12:0] c);
    return (c < MAX_ENTRIES) ? c + 13'd1 : 13'(MAX_ENTRIES);
  endfunction

  // Fold one accepted entry into the tallies; a last entry yields a verdict.
  task automatic score_entry(input in_beat_t b);
    longint d, ad, lhs, rhs;
    longint unsigned n, r, g, bd, z;
    logic acc;
    out_beat_t res;
    n_seen = sat_inc(n_seen);
    if (b.entry_value == 0) begin
      n_zero = sat_inc(n_zero);
      n_bad  = sat_inc(n_bad);
    end else begin
      d   = longint'(b.entry_value) - longint'(b.seed_value);
      ad  = (d < 0) ? -d : d;
      lhs = ad * 256;
      rhs = longint'(tol_q88) * longint'(b.seed_value);
      if (lhs <= rhs) begin
        n_good = sat_inc(n_good);
      end else begin
        n_bad = sat_inc(n_bad);
        nz_failed = 1'b1;
      end
    end
    if (b.last_entry) begin
      n  = n_seen;
      r  = drop_q016;
      g  = n_good;
      bd = n_bad;
      z  = n_zero;
      // verdict follows the mode carried by the last beat only
      if (b.mode == MODE_ROW) begin
        acc = (bd <= ((n * r) >> 16)) && (g * 65536 >= n * (65536 - r));
      end else begin
        acc = (z * 65536 <= n * r) && !nz_failed;
      end
      res.accepted    = acc;
      res.good_count  = n_good;
      res.bad_count   = n_bad;
      res.entry_total = n_seen;
      verdict_q.insert(verdict_q.size(), res);
      n_good = '0;
      n_bad = '0;
      n_zero = '0;
      n_seen = '0;
      nz_failed = 1'b0;
    end
  endtask

  // Driver: offers queued beats, holds payload while stalled, random gaps.
  int unsigned src_gap = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_beat  <= '0;
      src_gap  <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        score_entry(in_beat);
        beats_in++;
      end
      if (!in_valid || !in_stall) begin
        if (src_gap != 0) begin
          src_gap  <= src_gap - 1;
          in_valid <= 1'b0;
        end else if (entry_q.size() != 0 && !calm && $urandom_range(99) < src_gap_pct) begin
          src_gap  <= $urandom_range(3);
          in_valid <= 1'b0;
        end else if (entry_q.size() != 0) begin
          in_beat  <= entry_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_verdict(input out_beat_t got);
    out_beat_t want;
    if (verdict_q.size() == 0) begin
      $error("result beat with no verdict pending: %p", got);
      mismatches++;
    end else begin
      want = verdict_q.pop_front();
      if (got.accepted !== want.accepted) begin
        $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
        mismatches++;
      end
      if (got.good_count !== want.good_count) begin
        $error("good_count: expected %0d, got %0d", want.good_count, got.good_count);
        mismatches++;
      end
      if (got.bad_count !== want.bad_count) begin
        $error("bad_count: expected %0d, got %0d", want.bad_count, got.bad_count);
        mismatches++;
      end
      if (got.entry_total !== want.entry_total) begin
        $error("entry_total: expected %0d, got %0d", want.entry_total, got.entry_total);
        mismatches++;
      end
    end
    verdicts_seen++;
  endtask

  // Monitor: checks result beats; random stall bursts plus one long hold-off
  // so the block backs up and stalls its entry side.
  int unsigned snk_gap = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
      snk_gap   <= 0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) check_verdict(out_beat);
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && verdicts_seen == 40) begin
        hold_left <= LONG_HOLD;
        hold_done <= 1'b1;
        out_stall <= 1'b1;
      end else if (snk_gap != 0) begin
        snk_gap   <= snk_gap - 1;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(99) < snk_gap_pct) begin
        snk_gap   <= $urandom_range(3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Block idle: nothing queued, nothing offered, no verdict outstanding.
  task automatic wait_idle();
    while (entry_q.size() != 0 || in_valid || verdict_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_MAX_REL_DIFF) tol_q88 = val;
    else drop_q016 = val;
  endtask

  task automatic push_one(input logic m, input logic [31:0] v, input logic [31:0] s,
                          input logic last);
    in_beat_t b;
    b.mode        = m;
    b.entry_value = v;
    b.seed_value  = s;
    b.last_entry  = last;
    entry_q.insert(entry_q.size(), b);
  endtask

  // Mostly a positive seed with an entry placed around the tolerance edge;
  // noise beats are raw 32-bit values, negative seeds and zero entries included.
  function automatic in_beat_t make_entry(input logic noise);
    in_beat_t b;
    longint s, maxd, d, v;
    int unsigned pick;
    b.mode = 1'($urandom_range(1));
    b.last_entry = 1'b0;
    if (noise) begin
      b.entry_value = $urandom;
      b.seed_value  = $urandom;
      if ($urandom_range(3) == 0) b.entry_value = '0;
      return b;
    end
    s = ($urandom_range(3) == 0) ? longint'($urandom_range(32'h7fff_ffff, 1))
                                 : longint'($urandom_range(32'h0010_0000, 1));
    maxd = (longint'(tol_q88) * s) / 256;
    pick = $urandom_range(99);
    if (pick < 15) d = -s;  // dropout
    else if (pick < 70) d = longint'({$urandom, $urandom} % (2 * maxd + 1)) - maxd;
    else if (pick < 80) d = $urandom_range(1) ? maxd : -maxd;
    else if (pick < 92) d = (maxd + 1 + $urandom_range(3)) * ($urandom_range(1) ? 1 : -1);
    else d = (maxd + 1 + $urandom_range(32'h10000)) * ($urandom_range(1) ? 1 : -1);
    v = s + d;
    if (v > 64'sd2147483647 || v < -64'sd2147483648) v = s - d;
    if (v > 64'sd2147483647 || v < -64'sd2147483648) v = s;
    b.entry_value = v[31:0];
    b.seed_value  = s[31:0];
    return b;
  endfunction

  task automatic push_vector(input int unsigned len, input int unsigned noise_pct);
    in_beat_t b;
    for (int unsigned i = 0; i < len; i++) begin
      b = make_entry($urandom_range(99) < noise_pct);
      b.last_entry = (i == len - 1);
      entry_q.insert(entry_q.size(), b);
    end
  endtask

  // One register setting, then random candidates up to the beat budget.
  task automatic run_phase(input logic [15:0] tol, input logic [15:0] drop,
                           input int unsigned budget, input int unsigned sgap,
                           input int unsigned kgap);
    int unsigned queued;
    int unsigned len;
    int unsigned sel;
    wait_idle();
    write_reg(REG_MAX_REL_DIFF, tol);
    write_reg(REG_DROPOUT_RATE, drop);
    src_gap_pct = sgap;
    snk_gap_pct = kgap;
    settings_run++;
    queued = 0;
    while (queued < budget) begin
      sel = $urandom_range(9);
      if (sel < 6) len = $urandom_range(6, 1);
      else if (sel < 9) len = $urandom_range(20, 7);
      else len = $urandom_range(60, 21);
      // most candidates are clean; one in five is junk throughout
      push_vector(len, ($urandom_range(4) == 0) ? 100 : $urandom_range(10));
      queued += len;
    end
  endtask

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    src_gap_pct = 25;
    snk_gap_pct = 25;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed, reset settings (tolerance 1.0, no dropouts allowed).
    push_one(MODE_ROW, 32'h0001_0000, 32'h0001_0000, 1'b1);
    push_one(MODE_COL, 32'h0000_0000, 32'h0001_0000, 1'b1);
    push_one(MODE_ROW, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
    push_one(MODE_COL, 32'h8000_0000, 32'h0000_0001, 1'b1);
    push_one(MODE_COL, 32'hffff_0000, 32'hffff_0000, 1'b1);  // negative seed
    push_one(MODE_ROW, 32'h0000_0005, 32'h0000_0000, 1'b1);  // zero seed
    // tolerance edge: 2s passes, 2s+1 fails; last beat's mode rules
    push_one(MODE_COL, 32'h0002_0000, 32'h0001_0000, 1'b0);
    push_one(MODE_COL, 32'h0002_0001, 32'h0001_0000, 1'b0);
    push_one(MODE_COL, 32'h0000_0000, 32'h0001_0000, 1'b0);
    push_one(MODE_COL, 32'h0000_0000, 32'h0000_0000, 1'b0);
    push_one(MODE_ROW, 32'h0001_0000, 32'h0001_0000, 1'b1);
    push_one(MODE_ROW, 32'h0001_0000, 32'h0001_0000, 1'b0);
    push_one(MODE_ROW, 32'h0001_8000, 32'h0001_0000, 1'b0);
    push_one(MODE_COL, 32'h0000_8000, 32'h0001_0000, 1'b1);
    push_one(MODE_ROW, 32'h7fff_ffff, 32'h0000_0001, 1'b1);
    push_one(MODE_COL, 32'h8000_0000, 32'h8000_0000, 1'b1);
    wait_idle();
    // Zero tolerance, dropout rate 0xffff: only exact matches pass.
    write_reg(REG_MAX_REL_DIFF, 16'd0);
    write_reg(REG_DROPOUT_RATE, 16'hffff);
    push_one(MODE_COL, 32'hffff_fffb, 32'hffff_fffb, 1'b0);
    push_one(MODE_COL, 32'h0000_0000, 32'h0000_0003, 1'b0);
    push_one(MODE_COL, 32'h0000_0007, 32'h0000_0007, 1'b1);
    push_one(MODE_ROW, 32'h0000_0008, 32'h0000_0007, 1'b0);
    push_one(MODE_ROW, 32'h0000_0000, 32'h0000_0001, 1'b1);
    settings_run++;

    // Random part across settings; phase two runs with no idling at all.
    run_phase(16'd256,            16'd0,              140, 20, 20);
    run_phase(16'd26,             16'd6554,           140,  0,  0);
    run_phase(16'hffff,           16'hffff,           140, 30, 10);
    run_phase(16'd0,              16'd32768,          140, 10, 35);
    run_phase(16'($urandom_range(1024)), 16'($urandom_range(16'hffff)), 140, 25, 25);
    run_phase(16'($urandom_range(16'hffff)), 16'($urandom_range(16'hffff)), 140, 15, 30);
    run_phase(16'd128,            16'd13107,          140, 35, 15);

    // Last stretch: no idling on either side.
    wait_idle();
    calm = 1'b1;
    run_phase(16'($urandom_range(2048)), 16'($urandom_range(16'hffff)), 120, 0, 0);

    wait_idle();
    $display("Run covered %0d entry beats and %0d verdicts under %0d register settings,",
             beats_in, verdicts_seen, settings_run);
    $display("including a long result hold-off that backed up the entry side.");
    if (mismatches == 0 && verdict_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
